[rtl/pbe3_pkg.sv]
// shared types and constants for the packed binary 3x3 erosion core
// no dependencies

package pbe3_pkg;

   localparam int PIX_W        = 8;
   localparam int LINE_W       = 2 * PIX_W;
   localparam int ROW_BYTES_W  = 9;
   localparam int FRAME_ROWS_W = 13;
   localparam int ROW_CNT_W    = 12;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [FRAME_ROWS_W-1:0] MAX_FRAME_ROWS = 13'd4096;
   localparam logic [FRAME_ROWS_W-1:0] MIN_FRAME_ROWS = 13'd3;
   localparam logic [ROW_BYTES_W-1:0]  RESET_ROW_BYTES = 9'd256;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_BYTES  = 1'b0,
      CSR_FRAME_ROWS = 1'b1
   } csr_index_type;

   // per-beat position flags from the counter to the erosion stage
   typedef struct packed {
      logic emit;
      logic last_col;
      logic last_row;
   } pos_flags_type;

endpackage

[rtl/pbe3_line_mem.sv]
// two-row line store: one write port, one read port with registered data
// depends on pbe3_pkg

module pbe3_line_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [pbe3_pkg::LINE_W-1:0]  wr_data,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [pbe3_pkg::LINE_W-1:0]  rd_data
);
   import pbe3_pkg::*;

   logic [LINE_W-1:0] mem_ff [DEPTH];
   logic [LINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pbe3_pos_counter.sv]
// column and row position counters with clamped row width and frame height
// depends on pbe3_pkg

module pbe3_pos_counter #(
   parameter int MAX_ROW_BYTES = 256,
   parameter int AW            = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              frame_start,
   input  logic [pbe3_pkg::ROW_BYTES_W-1:0]  row_bytes,
   input  logic [pbe3_pkg::FRAME_ROWS_W-1:0] frame_rows,
   output logic [AW-1:0]                     col_addr,
   output pbe3_pkg::pos_flags_type           flags
);
   import pbe3_pkg::*;

   localparam int CMPW = (AW + 1 > ROW_BYTES_W) ? AW + 1 : ROW_BYTES_W;
   localparam logic [CMPW-1:0] MAX_W = CMPW'(MAX_ROW_BYTES);
   localparam logic [CMPW-1:0] MIN_W = CMPW'(3);

   logic [AW-1:0]        col_cnt_ff, col_cnt_in;
   logic [ROW_CNT_W-1:0] row_cnt_ff, row_cnt_in;

   logic [AW-1:0]           col_cur;
   logic [ROW_CNT_W-1:0]    row_cur;
   logic [CMPW-1:0]         width_ext, width_eff, width_m1, col_ext;
   logic [FRAME_ROWS_W-1:0] height_eff, height_m1;
   logic                    last_col, last_row;

   always_comb begin
      width_ext = CMPW'(row_bytes);
      if (width_ext < MIN_W) begin
         width_eff = MIN_W;
      end else if (width_ext > MAX_W) begin
         width_eff = MAX_W;
      end else begin
         width_eff = width_ext;
      end
      width_m1 = width_eff - CMPW'(1);

      if (frame_rows < MIN_FRAME_ROWS) begin
         height_eff = MIN_FRAME_ROWS;
      end else if (frame_rows > MAX_FRAME_ROWS) begin
         height_eff = MAX_FRAME_ROWS;
      end else begin
         height_eff = frame_rows;
      end
      height_m1 = height_eff - FRAME_ROWS_W'(1);
   end

   always_comb begin
      col_cur  = frame_start ? '0 : col_cnt_ff;
      row_cur  = frame_start ? '0 : row_cnt_ff;
      col_ext  = CMPW'(col_cur);
      last_col = (col_ext >= width_m1);
      last_row = (FRAME_ROWS_W'(row_cur) >= height_m1);

      flags.emit     = (row_cur >= ROW_CNT_W'(2)) && (col_ext >= CMPW'(2));
      flags.last_col = last_col;
      flags.last_row = last_row;
      col_addr       = col_cur;

      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (advance) begin
         if (last_col) begin
            col_cnt_in = '0;
            row_cnt_in = last_row ? '0 : row_cur + ROW_CNT_W'(1);
         end else begin
            col_cnt_in = col_cur + AW'(1);
            row_cnt_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

endmodule

[rtl/pbe3_erode_unit.sv]
// read-modify-write stage: vertical and, line store update, shift and output register
// depends on pbe3_pkg

module pbe3_erode_unit #(
   parameter int AW = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic [pbe3_pkg::PIX_W-1:0]   load_px,
   input  logic [AW-1:0]                load_addr,
   input  pbe3_pkg::pos_flags_type      load_flags,
   input  logic [pbe3_pkg::LINE_W-1:0]  rd_data,
   output logic                         busy,
   output logic                         wr_en,
   output logic [AW-1:0]                wr_addr,
   output logic [pbe3_pkg::LINE_W-1:0]  wr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pbe3_pkg::PIX_W-1:0]   rsp_eroded_byte,
   output logic                         rsp_row_end,
   output logic                         rsp_frame_end
);
   import pbe3_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]    s1_px_ff;
   logic [AW-1:0]       s1_addr_ff;
   pos_flags_type       s1_flags_ff;
   logic                s1_fwd_ff;
   logic [LINE_W-1:0]   s1_fwd_data_ff;
   logic [PIX_W-1:0]    col_prev_ff, col_prev_in;
   logic [PIX_W-1:0]    col_prev2_ff, col_prev2_in;
   logic                out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]    out_byte_ff;
   logic                out_row_end_ff, out_frame_end_ff;

   logic                s1_fire, fwd_hit;
   logic [LINE_W-1:0]   entry;
   logic [PIX_W-1:0]    col_and, left_nb, right_nb, result;

   always_comb begin
      s1_fire  = s1_valid_ff && (!s1_flags_ff.emit || !out_valid_ff || !rsp_stall);
      busy     = s1_valid_ff && !s1_fire;
      // entry written as this beat was loaded beats the stale memory read
      entry    = s1_fwd_ff ? s1_fwd_data_ff : rd_data;
      col_and  = entry[LINE_W-1:PIX_W] & entry[PIX_W-1:0] & s1_px_ff;
      left_nb  = {col_prev2_ff[0], col_prev_ff[PIX_W-1:1]};
      right_nb = {col_prev_ff[PIX_W-2:0], col_and[PIX_W-1]};
      result   = col_prev_ff & left_nb & right_nb;

      wr_en    = s1_fire;
      wr_addr  = s1_addr_ff;
      wr_data  = {entry[PIX_W-1:0], s1_px_ff};
      fwd_hit  = s1_fire && (s1_addr_ff == load_addr);

      s1_valid_in = load ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

      col_prev_in  = s1_fire ? col_and : col_prev_ff;
      col_prev2_in = s1_fire ? col_prev_ff : col_prev2_ff;

      out_valid_in = out_valid_ff;
      if (s1_fire && s1_flags_ff.emit) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         col_prev_ff  <= '1;
         col_prev2_ff <= '1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         col_prev_ff  <= col_prev_in;
         col_prev2_ff <= col_prev2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_px_ff       <= load_px;
         s1_addr_ff     <= load_addr;
         s1_flags_ff    <= load_flags;
         s1_fwd_ff      <= fwd_hit;
         s1_fwd_data_ff <= wr_data;
      end
      if (s1_fire && s1_flags_ff.emit) begin
         out_byte_ff      <= result;
         out_row_end_ff   <= s1_flags_ff.last_col;
         out_frame_end_ff <= s1_flags_ff.last_col && s1_flags_ff.last_row;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_eroded_byte = out_byte_ff;
   assign rsp_row_end     = out_row_end_ff;
   assign rsp_frame_end   = out_frame_end_ff;

endmodule

[rtl/packed_binary_erosion_3x3_core.sv]
// top level of the bit-packed 3x3 binary erosion core
// depends on pbe3_pkg, pbe3_pos_counter, pbe3_line_mem, pbe3_erode_unit
//
// usage:
//   req_ channel takes one byte of a padded binary frame per beat, raster
//   order, msb = leftmost pixel; req_frame_start marks row 0, column 0
//   rsp_ channel gives one eroded byte per interior input byte, for the
//   byte one row and one column back, with row_end and frame_end flags
//   csr_ port writes row_bytes (index 0) and frame_rows (index 1) while idle
// throughput: one beat per cycle sustained while rsp_stall is low; the
//   line store is read at acceptance and written back when the read stage
//   fires; a forwarding path covers an entry read as it is written
// output: a beat accepted into the read stage has its result loaded into
//   the output register on the edge on which that stage fires
// stall: the output register holds a result until taken; the next beat is
//   still accepted into the read stage, and req_stall rises only when that
//   stage holds a result that cannot move on
// reset: counters to row 0 column 0, column ands to all ones, registers to
//   256 / 4096; the line store is not cleared, the border rows fill it

module packed_binary_erosion_3x3_core #(
   parameter int MAX_ROW_BYTES = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [pbe3_pkg::PIX_W-1:0]         req_pixel_byte,
   input  logic                               req_frame_start,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [pbe3_pkg::PIX_W-1:0]         rsp_eroded_byte,
   output logic                               rsp_row_end,
   output logic                               rsp_frame_end,
   input  logic                               csr_write_en,
   input  logic [pbe3_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pbe3_pkg::CSR_DATA_W-1:0]    csr_data
);
   import pbe3_pkg::*;

   // column index width: just enough for MAX_ROW_BYTES entries
   localparam int AW = $clog2(MAX_ROW_BYTES);

   logic [ROW_BYTES_W-1:0]  row_bytes_ff, row_bytes_in;
   logic [FRAME_ROWS_W-1:0] frame_rows_ff, frame_rows_in;

   logic                accept, busy;
   logic [AW-1:0]       col_addr;
   pos_flags_type       flags;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [LINE_W-1:0]   wr_data, rd_data;

   // configuration registers
   always_comb begin
      row_bytes_in  = row_bytes_ff;
      frame_rows_in = frame_rows_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_ROW_BYTES:  row_bytes_in  = csr_data[ROW_BYTES_W-1:0];
            CSR_FRAME_ROWS: frame_rows_in = csr_data;
            default: begin
               row_bytes_in  = row_bytes_ff;
               frame_rows_in = frame_rows_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff  <= RESET_ROW_BYTES;
         frame_rows_ff <= MAX_FRAME_ROWS;
      end else begin
         row_bytes_ff  <= row_bytes_in;
         frame_rows_ff <= frame_rows_in;
      end
   end

   // a beat enters whenever the read-modify-write stage can move on
   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   pbe3_pos_counter #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES),
      .AW            (AW)
   ) u_pos (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .frame_start (req_frame_start),
      .row_bytes   (row_bytes_ff),
      .frame_rows  (frame_rows_ff),
      .col_addr    (col_addr),
      .flags       (flags)
   );

   // line store: high byte is two rows back, low byte one row back
   pbe3_line_mem #(
      .DEPTH (MAX_ROW_BYTES),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (col_addr),
      .rd_data (rd_data)
   );

   pbe3_erode_unit #(
      .AW (AW)
   ) u_erode (
      .clock           (clock),
      .reset           (reset),
      .load            (accept),
      .load_px         (req_pixel_byte),
      .load_addr       (col_addr),
      .load_flags      (flags),
      .rd_data         (rd_data),
      .busy            (busy),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_eroded_byte (rsp_eroded_byte),
      .rsp_row_end     (rsp_row_end),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule
